/* rtl/core/pdr_pkg.sv */
// Shared types and constants for the primitive direction reducer.
package pdr_pkg;
	localparam int COORD_WIDTH = 64;
	localparam int MAG_WIDTH = COORD_WIDTH - 1;
	localparam int STEP_WIDTH = $clog2(MAG_WIDTH + 1);

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ZERO = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// One classified request passed from the front to the back.
	typedef struct packed {
		logic [MAG_WIDTH-1:0] mag_x;
		logic [MAG_WIDTH-1:0] mag_y;
		logic [MAG_WIDTH-1:0] mag_z;
		logic neg_x;
		logic neg_y;
		logic neg_z;
		status_t status;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_GCD,
		BK_DIV,
		BK_OUT
	} back_state_t;

	// Sign extend the low COORD_WIDTH bits of a 64-bit input.
	function automatic logic signed [COORD_WIDTH:0] sext(input logic [63:0] v);
		return {v[COORD_WIDTH-1], v[COORD_WIDTH-1:0]};
	endfunction
endpackage

/* rtl/core/pdr_front.sv */
// Front part: offsets, magnitudes and error classification.
module pdr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic [63:0] first_x,
	input  logic [63:0] first_y,
	input  logic [63:0] first_z,
	input  logic [63:0] second_x,
	input  logic [63:0] second_y,
	input  logic [63:0] second_z,
	input  logic push,
	output logic full,
	output logic job_valid,
	output pdr_pkg::job_t job,
	input  logic job_take
);
	logic signed [pdr_pkg::COORD_WIDTH:0] dx, dy, dz;
	logic [pdr_pkg::COORD_WIDTH:0] ax, ay, az;
	logic ovf;
	pdr_pkg::job_t job_q;
	logic valid_q;

	always_comb begin
		dx = pdr_pkg::sext(second_x) - pdr_pkg::sext(first_x);
		dy = pdr_pkg::sext(second_y) - pdr_pkg::sext(first_y);
		dz = pdr_pkg::sext(second_z) - pdr_pkg::sext(first_z);
		ax = dx[pdr_pkg::COORD_WIDTH] ? -dx : dx;
		ay = dy[pdr_pkg::COORD_WIDTH] ? -dy : dy;
		az = dz[pdr_pkg::COORD_WIDTH] ? -dz : dz;
		// A magnitude needs to fit in COORD_WIDTH-1 bits.
		ovf = (ax[pdr_pkg::COORD_WIDTH:pdr_pkg::MAG_WIDTH] != '0)
			|| (ay[pdr_pkg::COORD_WIDTH:pdr_pkg::MAG_WIDTH] != '0)
			|| (az[pdr_pkg::COORD_WIDTH:pdr_pkg::MAG_WIDTH] != '0);
	end

	assign full = valid_q && !job_take;
	assign job_valid = valid_q;
	assign job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push && !full) begin
			valid_q <= 1'b1;
		end else if (job_take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			job_q.mag_x <= ax[pdr_pkg::MAG_WIDTH-1:0];
			job_q.mag_y <= ay[pdr_pkg::MAG_WIDTH-1:0];
			job_q.mag_z <= az[pdr_pkg::MAG_WIDTH-1:0];
			job_q.neg_x <= dx[pdr_pkg::COORD_WIDTH];
			job_q.neg_y <= dy[pdr_pkg::COORD_WIDTH];
			job_q.neg_z <= dz[pdr_pkg::COORD_WIDTH];
			if (ovf) begin
				job_q.status <= pdr_pkg::ST_OVERFLOW;
			end else if (ax == '0 && ay == '0 && az == '0) begin
				job_q.status <= pdr_pkg::ST_ZERO;
			end else begin
				job_q.status <= pdr_pkg::ST_OK;
			end
		end
	end
endmodule

/* rtl/core/pdr_back.sv */
// Back part: iterative gcd, three restoring divisions and the result register.
module pdr_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  pdr_pkg::job_t job,
	output logic job_take,
	output logic [63:0] dir_x,
	output logic [63:0] dir_y,
	output logic [63:0] dir_z,
	output logic [62:0] common_divisor,
	output logic [1:0] status,
	output logic empty,
	input  logic pop
);
	localparam int MW = pdr_pkg::MAG_WIDTH;
	localparam int CW = pdr_pkg::COORD_WIDTH;
	localparam int STEPW = pdr_pkg::STEP_WIDTH;

	pdr_pkg::back_state_t state_q, state_d;
	logic [MW-1:0] a_q, b_q, g_q;
	logic [MW-1:0] m_q [3];
	logic [MW-1:0] quo_q [3];
	logic [MW:0] rem_q [3];
	logic [2:0] neg_q;
	logic [1:0] pass_q;
	logic [STEPW-1:0] cnt_q;
	logic [STEPW-1:0] k_q;
	pdr_pkg::job_t job_q;
	logic [MW-1:0] lesser, greater;
	logic [MW:0] trial [3];
	logic out_full_q;

	// Helpers for one binary gcd step over a_q, b_q (a zero operand takes the other) and the divider trial subtractions.
	always_comb begin
		lesser = (a_q < b_q) ? a_q : b_q;
		greater = (a_q < b_q) ? b_q : a_q;
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_q[i][MW-1:0], m_q[i][MW-1]} - {1'b0, g_q};
		end
	end

	always_comb begin
		state_d = state_q;
		job_take = 1'b0;
		unique case (state_q)
			pdr_pkg::BK_IDLE: begin
				if (job_valid) begin
					job_take = 1'b1;
					state_d = (job.status == pdr_pkg::ST_OK) ? pdr_pkg::BK_GCD
						: pdr_pkg::BK_OUT;
				end
			end
			pdr_pkg::BK_GCD: begin
				if (pass_q == 2'd2 && (a_q == '0 || b_q == '0)) begin
					state_d = pdr_pkg::BK_DIV;
				end
			end
			pdr_pkg::BK_DIV: begin
				if (cnt_q == STEPW'(MW - 1)) begin
					state_d = pdr_pkg::BK_OUT;
				end
			end
			pdr_pkg::BK_OUT: begin
				if (!out_full_q) begin
					state_d = pdr_pkg::BK_IDLE;
				end
			end
			default: state_d = pdr_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdr_pkg::BK_IDLE;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pdr_pkg::BK_OUT && !out_full_q) begin
				out_full_q <= 1'b1;
			end else if (pop) begin
				out_full_q <= 1'b0;
			end
		end
	end

	// Gcd runs pairwise: first (x, y), then (result, z). Each step either
	// strips a common factor of two, a lone factor of two, or subtracts; a zero operand ends the pass.
	always_ff @(posedge clk) begin
		unique case (state_q)
			pdr_pkg::BK_IDLE: begin
				job_q <= job;
				m_q[0] <= job.mag_x;
				m_q[1] <= job.mag_y;
				m_q[2] <= job.mag_z;
				neg_q <= {job.neg_z, job.neg_y, job.neg_x};
				a_q <= job.mag_x;
				b_q <= job.mag_y;
				k_q <= '0;
				pass_q <= 2'd1;
			end
			pdr_pkg::BK_GCD: begin
				if (a_q == '0 || b_q == '0) begin
					g_q <= (greater << k_q);
					if (pass_q == 2'd1) begin
						a_q <= greater << k_q;
						b_q <= m_q[2];
						k_q <= '0;
						pass_q <= 2'd2;
					end
					cnt_q <= '0;
					for (int i = 0; i < 3; i++) begin
						rem_q[i] <= '0;
						quo_q[i] <= '0;
					end
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + STEPW'(1);
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else begin
					a_q <= lesser;
					b_q <= greater - lesser;
				end
			end
			pdr_pkg::BK_DIV: begin
				cnt_q <= cnt_q + STEPW'(1);
				for (int i = 0; i < 3; i++) begin
					m_q[i] <= m_q[i] << 1;
					if (!trial[i][MW]) begin
						rem_q[i] <= trial[i];
						quo_q[i] <= {quo_q[i][MW-2:0], 1'b1};
					end else begin
						rem_q[i] <= {rem_q[i][MW-1:0], m_q[i][MW-1]};
						quo_q[i] <= {quo_q[i][MW-2:0], 1'b0};
					end
				end
			end
			pdr_pkg::BK_OUT: begin
				if (!out_full_q) begin
					status <= job_q.status;
					if (job_q.status == pdr_pkg::ST_OK) begin
						dir_x <= 64'(neg_q[0] ? -{1'b0, quo_q[0]} : {1'b0, quo_q[0]});
						dir_y <= 64'(neg_q[1] ? -{1'b0, quo_q[1]} : {1'b0, quo_q[1]});
						dir_z <= 64'(neg_q[2] ? -{1'b0, quo_q[2]} : {1'b0, quo_q[2]});
						common_divisor <= 63'(g_q);
					end else begin
						dir_x <= '0;
						dir_y <= '0;
						dir_z <= '0;
						common_divisor <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign empty = !out_full_q;
endmodule

/* rtl/core/primitive_direction_reducer.sv */
// Top level of the primitive direction reducer.
// Each request takes the offset of two 3D positions, finds the gcd of the
// component magnitudes with a binary shift-subtract unit and divides each
// component by it in three restoring dividers working side by side. The
// front stage classifies one request and holds it while the back unit
// works; the back unit takes the request, runs binary gcd steps over the
// two pairwise passes with a closing step at the end of each pass, runs
// the divide steps and registers the result, so the gcd loop and the
// divide set the time. Errors skip both loops and go from taking the
// request straight to registering the result. A finished result waits in
// the output register while the next request is taken; a new result is
// registered only once the previous one has been popped.
module primitive_direction_reducer (
	input  logic clk,
	input  logic arst_n,
	input  logic [63:0] first_x,
	input  logic [63:0] first_y,
	input  logic [63:0] first_z,
	input  logic [63:0] second_x,
	input  logic [63:0] second_y,
	input  logic [63:0] second_z,
	input  logic push,
	output logic full,
	output logic [63:0] dir_x,
	output logic [63:0] dir_y,
	output logic [63:0] dir_z,
	output logic [62:0] common_divisor,
	output logic [1:0] status,
	output logic empty,
	input  logic pop
);
	logic job_valid, job_take;
	pdr_pkg::job_t job;

	pdr_front u_front (
		.clk, .arst_n, .first_x, .first_y, .first_z,
		.second_x, .second_y, .second_z, .push, .full,
		.job_valid, .job, .job_take
	);

	pdr_back u_back (
		.clk, .arst_n, .job_valid, .job, .job_take,
		.dir_x, .dir_y, .dir_z, .common_divisor, .status, .empty, .pop
	);

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid) else $error("job taken while none held");
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == pdr_pkg::ST_OK) |-> common_divisor != '0)
		else $error("ok result with zero divisor");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != pdr_pkg::ST_OK) |-> (common_divisor == '0 && dir_x == '0))
		else $error("error result not cleared");
endmodule
